// File: design/drc_pkg.sv
package drc_pkg;

    // map and texture geometry
    localparam int MAP_SIZE = 128;
    localparam int MAP_BITS = $clog2(MAP_SIZE);
    localparam int ADDR_W   = 2 * MAP_BITS;
    localparam int COORD_W  = 7;
    localparam int POS_W    = ((MAP_BITS > COORD_W) ? MAP_BITS : COORD_W) + 2;
    localparam int TEX_SIZE = 64;
    localparam int TEX_BITS = $clog2(TEX_SIZE);

    // field widths
    localparam int FRAC    = 16;
    localparam int EYE_W   = 23;
    localparam int DIR_W   = 18;
    localparam int TILE_W  = 3;
    localparam int DIST_W  = 24;
    localparam int HGT_W   = 16;
    localparam int STEPS_W = 8;
    localparam int MASK_W  = 8;
    localparam int MIN_W   = 16;
    localparam int SH_W    = 12;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    // internal arithmetic widths
    localparam int DELTA_W = 2 * FRAC + 1;
    localparam int SD_W    = DELTA_W + STEPS_W;
    localparam int NUM_W   = DELTA_W;
    localparam int DEN_W   = 24;
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W  = $clog2(DIV_STEPS);
    localparam int MA_W    = 25;
    localparam int MB_W    = 18;
    localparam int MP_W    = MA_W + MB_W;
    localparam int LO_W    = MB_W - 1;
    localparam int HI_W    = DELTA_W - LO_W;
    localparam int ACC_W   = FRAC + 1 + LO_W;
    localparam int SUM_W   = FRAC + 1 + DELTA_W + 1;
    localparam int PT_W    = 2 * FRAC;

    localparam logic [FRAC:0]      FRAC_ONE = (FRAC + 1)'(1) << FRAC;
    localparam logic [DIST_W-1:0]  DIST_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKING_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
    localparam logic [OP_W-1:0] OP_WRITE     = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV_DELTA = 5'd3;
    localparam logic [OP_W-1:0] OP_DIV_HGT   = 5'd4;
    localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd5;
    localparam logic [OP_W-1:0] OP_DELTA_SET = 5'd6;
    localparam logic [OP_W-1:0] OP_MUL_LO    = 5'd7;
    localparam logic [OP_W-1:0] OP_MUL_HI    = 5'd8;
    localparam logic [OP_W-1:0] OP_SIDE_SET  = 5'd9;
    localparam logic [OP_W-1:0] OP_STEP      = 5'd10;
    localparam logic [OP_W-1:0] OP_CHECK     = 5'd11;
    localparam logic [OP_W-1:0] OP_DIST      = 5'd12;
    localparam logic [OP_W-1:0] OP_MUL_TEX   = 5'd13;
    localparam logic [OP_W-1:0] OP_TEX       = 5'd14;
    localparam logic [OP_W-1:0] OP_HGT_SET   = 5'd15;
    localparam logic [OP_W-1:0] OP_HGT_MAX   = 5'd16;
    localparam logic [OP_W-1:0] OP_OUT       = 5'd17;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            axis;
    } cmd_t;

    typedef struct packed {
        logic zero_x;
        logic zero_y;
        logic steps_left;
        logic in_map;
        logic blocking;
        logic hit;
        logic dist_zero;
        logic out_busy;
    } stat_t;

endpackage

// File: design/drc_ram.sv
module drc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/drc_ctrl.sv
module drc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           kind,
    output logic           in_ready,
    input  drc_pkg::stat_t stat,
    output drc_pkg::cmd_t  cmd
);
    import drc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DLT  = 4'd1;
    localparam logic [3:0] S_DDIV = 4'd2;
    localparam logic [3:0] S_DSET = 4'd3;
    localparam logic [3:0] S_MLO  = 4'd4;
    localparam logic [3:0] S_MHI  = 4'd5;
    localparam logic [3:0] S_SSET = 4'd6;
    localparam logic [3:0] S_WALK = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;
    localparam logic [3:0] S_DIST = 4'd9;
    localparam logic [3:0] S_TMUL = 4'd10;
    localparam logic [3:0] S_TEX  = 4'd11;
    localparam logic [3:0] S_HGT  = 4'd12;
    localparam logic [3:0] S_HDIV = 4'd13;
    localparam logic [3:0] S_HSET = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

    logic [3:0]        state_reg, state_next;
    logic              axis_reg, axis_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              zero_a;

    assign zero_a = axis_reg ? stat.zero_y : stat.zero_x;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        dcnt_next  = dcnt_reg;
        cmd.op     = OP_NOP;
        cmd.axis   = axis_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind)
                    begin
                        cmd.op     = OP_LOAD;
                        axis_next  = 1'b0;
                        state_next = S_DLT;
                    end
                    else
                    begin
                        cmd.op = OP_WRITE;
                    end
                end
            end
            S_DLT:
            begin
                if (zero_a)
                begin
                    axis_next = ~axis_reg;
                    if (axis_reg)
                    begin
                        state_next = S_MLO;
                    end
                end
                else
                begin
                    cmd.op     = OP_DIV_DELTA;
                    dcnt_next  = '0;
                    state_next = S_DDIV;
                end
            end
            S_DDIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (dcnt_reg == DCNT_LAST)
                begin
                    state_next = S_DSET;
                end
                else
                begin
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                end
            end
            S_DSET:
            begin
                cmd.op    = OP_DELTA_SET;
                axis_next = ~axis_reg;
                state_next = axis_reg ? S_MLO : S_DLT;
            end
            S_MLO:
            begin
                if (zero_a)
                begin
                    axis_next = ~axis_reg;
                    if (axis_reg)
                    begin
                        state_next = S_WALK;
                    end
                end
                else
                begin
                    cmd.op     = OP_MUL_LO;
                    state_next = S_MHI;
                end
            end
            S_MHI:
            begin
                cmd.op     = OP_MUL_HI;
                state_next = S_SSET;
            end
            S_SSET:
            begin
                cmd.op     = OP_SIDE_SET;
                axis_next  = ~axis_reg;
                state_next = axis_reg ? S_WALK : S_MLO;
            end
            S_WALK:
            begin
                if (stat.steps_left)
                begin
                    cmd.op     = OP_STEP;
                    state_next = S_CHK;
                end
                else
                begin
                    state_next = S_DIST;
                end
            end
            S_CHK:
            begin
                if (!stat.in_map)
                begin
                    state_next = S_DIST;
                end
                else
                begin
                    cmd.op     = OP_CHECK;
                    state_next = stat.blocking ? S_DIST : S_WALK;
                end
            end
            S_DIST:
            begin
                cmd.op     = OP_DIST;
                state_next = stat.hit ? S_TMUL : S_HGT;
            end
            S_TMUL:
            begin
                cmd.op     = OP_MUL_TEX;
                state_next = S_TEX;
            end
            S_TEX:
            begin
                cmd.op     = OP_TEX;
                state_next = S_HGT;
            end
            S_HGT:
            begin
                if (stat.dist_zero)
                begin
                    cmd.op     = OP_HGT_MAX;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_DIV_HGT;
                    dcnt_next  = '0;
                    state_next = S_HDIV;
                end
            end
            S_HDIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (dcnt_reg == DCNT_LAST)
                begin
                    state_next = S_HSET;
                end
                else
                begin
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                end
            end
            S_HSET:
            begin
                cmd.op     = OP_HGT_SET;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            dcnt_reg  <= dcnt_next;
        end
    end

endmodule

// File: design/drc_datapath.sv
module drc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  drc_pkg::cmd_t                       cmd,
    output drc_pkg::stat_t                      stat,
    input  logic                                cfg_we,
    input  logic [drc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [drc_pkg::CFG_W-1:0]           cfg_data,
    input  logic [drc_pkg::COORD_W-1:0]         cell_col,
    input  logic [drc_pkg::COORD_W-1:0]         cell_row,
    input  logic [drc_pkg::TILE_W-1:0]          tile_value,
    input  logic [drc_pkg::EYE_W-1:0]           eye_x,
    input  logic [drc_pkg::EYE_W-1:0]           eye_y,
    input  logic signed [drc_pkg::DIR_W-1:0]    ray_dx,
    input  logic signed [drc_pkg::DIR_W-1:0]    ray_dy,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic                                side,
    output logic [drc_pkg::TILE_W-1:0]          hit_tile,
    output logic [drc_pkg::COORD_W-1:0]         hit_col,
    output logic [drc_pkg::COORD_W-1:0]         hit_row,
    output logic [drc_pkg::DIST_W-1:0]          distance,
    output logic [drc_pkg::TEX_BITS-1:0]        tex_column,
    output logic [drc_pkg::HGT_W-1:0]           wall_height
);
    import drc_pkg::*;

    // configuration
    logic [STEPS_W-1:0] steps_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [DIST_W-1:0]  miss_reg;
    logic [MIN_W-1:0]   min_reg;
    logic [SH_W-1:0]    sh_reg;

    // ray state
    logic [EYE_W-1:0]        ex_reg, ey_reg;
    logic signed [DIR_W-1:0] rdx_reg, rdy_reg;
    logic signed [POS_W-1:0] mx_reg, my_reg, mx_next, my_next;
    logic [DELTA_W-1:0]      ddx_reg, ddy_reg;
    logic [SD_W-1:0]         sdx_reg, sdy_reg;
    logic [STEPS_W-1:0]      cnt_reg;
    logic                    side_reg, hit_reg;
    logic [TILE_W-1:0]       tile_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic [TEX_BITS-1:0]     tex_reg;
    logic [HGT_W-1:0]        hgt_reg;

    // shared divider and multiplier
    logic [DEN_W-1:0]        rem_reg, den_reg;
    logic [NUM_W-1:0]        quo_reg;
    logic [DEN_W:0]          div_trial;
    logic                    div_ge;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  prod_reg;
    logic [ACC_W-1:0]        acc_reg;

    // output word
    logic                    out_valid_reg;
    logic                    o_hit_reg, o_side_reg;
    logic [TILE_W-1:0]       o_tile_reg;
    logic [COORD_W-1:0]      o_col_reg, o_row_reg;
    logic [DIST_W-1:0]       o_dist_reg;
    logic [TEX_BITS-1:0]     o_tex_reg;
    logic [HGT_W-1:0]        o_hgt_reg;

    // axis-selected operands
    logic signed [DIR_W-1:0] dir_a;
    logic [DIR_W-1:0]        mag_a;
    logic [EYE_W-1:0]        eye_a;
    logic [DELTA_W-1:0]      dd_a;
    logic [FRAC:0]           frac_a, f_a;
    logic [SUM_W-1:0]        side_sum;

    logic                    zero_x, zero_y, go_x;
    logic signed [POS_W-1:0] mx_step, my_step;
    logic [SD_W-1:0]         pd_raw;
    logic [DIST_W-1:0]       pd_clamp;
    logic [PT_W-1:0]         pt;
    logic [TEX_BITS-1:0]     tex_raw;
    logic                    tex_flip;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [TILE_W-1:0]       ram_rdata;

    assign zero_x = (rdx_reg == '0);
    assign zero_y = (rdy_reg == '0);

    assign dir_a  = cmd.axis ? rdy_reg : rdx_reg;
    assign eye_a  = cmd.axis ? ey_reg : ex_reg;
    assign dd_a   = cmd.axis ? ddy_reg : ddx_reg;
    assign mag_a  = dir_a[DIR_W-1] ? DIR_W'(-dir_a) : DIR_W'(dir_a);
    assign frac_a = {1'b0, eye_a[FRAC-1:0]};
    assign f_a    = dir_a[DIR_W-1] ? frac_a : (FRAC_ONE - frac_a);

    // first side distance: f * delta split into low and high partial products
    assign side_sum = SUM_W'(acc_reg) + (SUM_W'(prod_reg[ACC_W-1:0]) << LO_W);

    // walk: the nearer grid line wins, ties step in y
    assign go_x    = !zero_x && (zero_y || (sdx_reg < sdy_reg));
    assign mx_step = mx_reg + (rdx_reg[DIR_W-1] ? POS_W'(-1) : POS_W'(1));
    assign my_step = my_reg + (rdy_reg[DIR_W-1] ? POS_W'(-1) : POS_W'(1));
    assign mx_next = (cmd.op == OP_STEP && go_x) ? mx_step : mx_reg;
    assign my_next = (cmd.op == OP_STEP && !go_x) ? my_step : my_reg;

    assign ram_raddr = {mx_next[MAP_BITS-1:0], my_next[MAP_BITS-1:0]};
    assign ram_waddr = (ADDR_W'(cell_col) << MAP_BITS) | ADDR_W'(cell_row);
    assign ram_we    = (cmd.op == OP_WRITE) && (32'(cell_col) < MAP_SIZE)
                       && (32'(cell_row) < MAP_SIZE);

    drc_ram #(
        .WIDTH (TILE_W),
        .DEPTH (MAP_SIZE * MAP_SIZE)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tile_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // restoring divider, one quotient bit per cycle
    assign div_trial = {rem_reg, quo_reg[NUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, den_reg});

    // perpendicular distance from the side that was stepped last
    always_comb
    begin
        pd_raw = '0;
        if (!side_reg)
        begin
            if (sdx_reg >= SD_W'(ddx_reg))
            begin
                pd_raw = sdx_reg - SD_W'(ddx_reg);
            end
        end
        else if (!zero_y && (sdy_reg >= SD_W'(ddy_reg)))
        begin
            pd_raw = sdy_reg - SD_W'(ddy_reg);
        end
        if (pd_raw < SD_W'(min_reg))
        begin
            pd_clamp = DIST_W'(min_reg);
        end
        else if (pd_raw > SD_W'(DIST_MAX))
        begin
            pd_clamp = DIST_MAX;
        end
        else
        begin
            pd_clamp = pd_raw[DIST_W-1:0];
        end
    end

    // hit point along the face, low 32 bits only matter
    assign pt = {(side_reg ? ex_reg[FRAC-1:0] : ey_reg[FRAC-1:0]), FRAC'(0)}
                + prod_reg[PT_W-1:0];
    assign tex_raw  = pt[PT_W-1:PT_W-TEX_BITS];
    assign tex_flip = side_reg ? rdy_reg[DIR_W-1]
                               : (!rdx_reg[DIR_W-1] && !zero_x);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_LO:
            begin
                mul_a = $signed(MA_W'(f_a));
                mul_b = $signed(MB_W'(dd_a[LO_W-1:0]));
            end
            OP_MUL_HI:
            begin
                mul_a = $signed(MA_W'(f_a));
                mul_b = $signed(MB_W'(dd_a[DELTA_W-1:LO_W]));
            end
            OP_MUL_TEX:
            begin
                mul_a = $signed(MA_W'(dist_reg));
                mul_b = side_reg ? rdx_reg : rdy_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        stat.zero_x     = zero_x;
        stat.zero_y     = zero_y;
        stat.steps_left = (cnt_reg < steps_reg);
        stat.in_map     = !mx_reg[POS_W-1] && ($unsigned(mx_reg) < POS_W'(MAP_SIZE))
                          && !my_reg[POS_W-1] && ($unsigned(my_reg) < POS_W'(MAP_SIZE));
        stat.blocking   = mask_reg[ram_rdata];
        stat.hit        = hit_reg;
        stat.dist_zero  = (dist_reg == '0);
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    // configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg     <= STEPS_W'(128);
            mask_reg      <= MASK_W'(34);
            miss_reg      <= DIST_W'(3276800);
            min_reg       <= MIN_W'(655);
            sh_reg        <= SH_W'(400);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_STEPS:     steps_reg <= cfg_data[STEPS_W-1:0];
                    REG_BLOCKING_MASK: mask_reg  <= cfg_data[MASK_W-1:0];
                    REG_MISS_DISTANCE: miss_reg  <= cfg_data[DIST_W-1:0];
                    REG_MIN_DISTANCE:  min_reg   <= cfg_data[MIN_W-1:0];
                    REG_SCREEN_HEIGHT: sh_reg    <= cfg_data[SH_W-1:0];
                    default:           ;
                endcase
            end
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ray datapath
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                ex_reg   <= eye_x;
                ey_reg   <= eye_y;
                rdx_reg  <= ray_dx;
                rdy_reg  <= ray_dy;
                mx_reg   <= POS_W'(eye_x[EYE_W-1:FRAC]);
                my_reg   <= POS_W'(eye_y[EYE_W-1:FRAC]);
                cnt_reg  <= '0;
                side_reg <= 1'b0;
                hit_reg  <= 1'b0;
                tile_reg <= '0;
                tex_reg  <= '0;
            end
            OP_DIV_DELTA:
            begin
                rem_reg <= '0;
                quo_reg <= NUM_W'(1) << (2 * FRAC);
                den_reg <= DEN_W'(mag_a);
            end
            OP_DIV_HGT:
            begin
                rem_reg <= '0;
                quo_reg <= NUM_W'(sh_reg) << FRAC;
                den_reg <= dist_reg;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? DEN_W'(div_trial - {1'b0, den_reg})
                                  : div_trial[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], div_ge};
            end
            OP_DELTA_SET:
            begin
                if (cmd.axis)
                begin
                    ddy_reg <= quo_reg;
                end
                else
                begin
                    ddx_reg <= quo_reg;
                end
            end
            OP_MUL_LO:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_MUL_HI:
            begin
                prod_reg <= mul_a * mul_b;
                acc_reg  <= prod_reg[ACC_W-1:0];
            end
            OP_SIDE_SET:
            begin
                if (cmd.axis)
                begin
                    sdy_reg <= SD_W'(side_sum >> FRAC);
                end
                else
                begin
                    sdx_reg <= SD_W'(side_sum >> FRAC);
                end
            end
            OP_STEP:
            begin
                cnt_reg <= cnt_reg + STEPS_W'(1);
                mx_reg  <= mx_next;
                my_reg  <= my_next;
                if (go_x)
                begin
                    sdx_reg  <= sdx_reg + SD_W'(ddx_reg);
                    side_reg <= 1'b0;
                end
                else
                begin
                    sdy_reg  <= sdy_reg + SD_W'(ddy_reg);
                    side_reg <= 1'b1;
                end
            end
            OP_CHECK:
            begin
                tile_reg <= ram_rdata;
                hit_reg  <= mask_reg[ram_rdata];
            end
            OP_DIST:
            begin
                dist_reg <= hit_reg ? pd_clamp : miss_reg;
            end
            OP_MUL_TEX:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_TEX:
            begin
                tex_reg <= tex_flip ? ~tex_raw : tex_raw;
            end
            OP_HGT_SET:
            begin
                hgt_reg <= (|quo_reg[NUM_W-1:HGT_W]) ? '1 : quo_reg[HGT_W-1:0];
            end
            OP_HGT_MAX:
            begin
                hgt_reg <= '1;
            end
            OP_OUT:
            begin
                o_hit_reg  <= hit_reg;
                o_side_reg <= side_reg;
                o_tile_reg <= tile_reg;
                o_col_reg  <= hit_reg ? mx_reg[COORD_W-1:0] : '0;
                o_row_reg  <= hit_reg ? my_reg[COORD_W-1:0] : '0;
                o_dist_reg <= dist_reg;
                o_tex_reg  <= tex_reg;
                o_hgt_reg  <= hgt_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign hit         = o_hit_reg;
    assign side        = o_side_reg;
    assign hit_tile    = o_tile_reg;
    assign hit_col     = o_col_reg;
    assign hit_row     = o_row_reg;
    assign distance    = o_dist_reg;
    assign tex_column  = o_tex_reg;
    assign wall_height = o_hgt_reg;

endmodule

// File: design/dda_grid_ray_caster_unit.sv
// grid ray caster: dda walk over a 128 x 128 map of 3-bit tiles
//
// input channel (in_valid / in_ready): a word with kind 0 writes tile_value at
// cell_col / cell_row and gives no result; kind 1 casts a ray from
// eye_x / eye_y along ray_dx / ray_dy and gives exactly one result word
// output channel (out_valid / out_ready): hit, side, hit_tile, hit_col,
// hit_row, distance, tex_column, wall_height held in an output register
// config port: cfg_we writes cfg_data into register cfg_index at once
// (max_steps, blocking_mask, miss_distance, min_distance, screen_height)
// one ray word at a time; a ray runs two reciprocals on the shared radix-2
// divider, the first side distances, the grid steps (one map read each, at
// most 255), then distance, texture and the wall height division
// reset: registers take their reset values, output empty, map contents
// undefined until written
// a stalled receiver holds the result in the output register; the next word
// is accepted meanwhile and waits only when its own result is ready
module dda_grid_ray_caster_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // config port
    input  logic                                cfg_we,
    input  logic [drc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [drc_pkg::CFG_W-1:0]           cfg_data,
    // input words
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [drc_pkg::COORD_W-1:0]         cell_col,
    input  logic [drc_pkg::COORD_W-1:0]         cell_row,
    input  logic [drc_pkg::TILE_W-1:0]          tile_value,
    input  logic [drc_pkg::EYE_W-1:0]           eye_x,
    input  logic [drc_pkg::EYE_W-1:0]           eye_y,
    input  logic signed [drc_pkg::DIR_W-1:0]    ray_dx,
    input  logic signed [drc_pkg::DIR_W-1:0]    ray_dy,
    // result words
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic                                side,
    output logic [drc_pkg::TILE_W-1:0]          hit_tile,
    output logic [drc_pkg::COORD_W-1:0]         hit_col,
    output logic [drc_pkg::COORD_W-1:0]         hit_row,
    output logic [drc_pkg::DIST_W-1:0]          distance,
    output logic [drc_pkg::TEX_BITS-1:0]        tex_column,
    output logic [drc_pkg::HGT_W-1:0]           wall_height
);
    import drc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: reciprocal setup, walk loop, finish and handoff
    drc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // map memory, divider, multiplier, walk registers, output register
    drc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cell_col    (cell_col),
        .cell_row    (cell_row),
        .tile_value  (tile_value),
        .eye_x       (eye_x),
        .eye_y       (eye_y),
        .ray_dx      (ray_dx),
        .ray_dy      (ray_dy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .side        (side),
        .hit_tile    (hit_tile),
        .hit_col     (hit_col),
        .hit_row     (hit_row),
        .distance    (distance),
        .tex_column  (tex_column),
        .wall_height (wall_height)
    );

    // a ray word makes the block busy
    a_ray_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind |=> !in_ready)
        else $error("ray word accepted but block still ready");

    // a tile write never creates a result
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !kind && !out_valid |=> !out_valid)
        else $error("result appeared after a tile write");

    // a miss reports no cell and no texture column
    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_col == '0 && hit_row == '0 && tex_column == '0)
        else $error("miss result carries cell or texture data");

    // zero distance saturates the wall height
    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && distance == '0 |-> wall_height == '1)
        else $error("wall height not saturated at zero distance");

endmodule
